### hw/rtl/rcsad_pkg.sv
package rcsad_pkg;

    localparam int PULSE_W    = 12;
    localparam int COUNT_W    = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [PULSE_W-1:0] FAILSAFE_YAW_BELOW    = 12'd1100;
    localparam logic [PULSE_W-1:0] FAILSAFE_OTHERS_ABOVE = 12'd1900;

    localparam logic [PULSE_W-1:0] STICK_LOW_RESET   = 12'd1200;
    localparam logic [PULSE_W-1:0] STICK_HIGH_RESET  = 12'd1800;
    localparam logic [COUNT_W-1:0] ARM_HOLD_RESET    = 16'd1000;
    localparam logic [COUNT_W-1:0] DISARM_HOLD_RESET = 16'd500;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STICK_LOW   = 2'd0,
        CFG_STICK_HIGH  = 2'd1,
        CFG_ARM_HOLD    = 2'd2,
        CFG_DISARM_HOLD = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [PULSE_W-1:0] yaw_pulse;
        logic [PULSE_W-1:0] throttle_pulse;
        logic [PULSE_W-1:0] roll_pulse;
        logic [PULSE_W-1:0] pitch_pulse;
    } stick_word_t;

    typedef struct packed {
        logic armed;
        logic arm_event;
        logic disarm_event;
        logic led_toggle;
        logic link_ok;
    } status_word_t;

    typedef struct packed {
        logic [PULSE_W-1:0] stick_low_limit;
        logic [PULSE_W-1:0] stick_high_limit;
        logic [COUNT_W-1:0] arm_hold_ticks;
        logic [COUNT_W-1:0] disarm_hold_ticks;
    } cfg_t;

endpackage

### hw/rtl/rcsad_eval.sv
module rcsad_eval #(
    parameter int BLINK_PERIOD = 20
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  rcsad_pkg::stick_word_t stick,
    input  rcsad_pkg::cfg_t       cfg,
    output rcsad_pkg::status_word_t status
);
    import rcsad_pkg::*;

    localparam int PHASE_W = (BLINK_PERIOD > 1) ? $clog2(BLINK_PERIOD) : 1;
    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(BLINK_PERIOD - 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};

    logic               armed_reg,        armed_next;
    logic [COUNT_W-1:0] arm_cnt_reg,      arm_cnt_next;
    logic [PHASE_W-1:0] arm_phase_reg,    arm_phase_next;
    logic [COUNT_W-1:0] disarm_cnt_reg,   disarm_cnt_next;
    logic [PHASE_W-1:0] disarm_phase_reg, disarm_phase_next;

    logic               left_arm, right_arm, disarm_gesture;
    logic [COUNT_W-1:0] cnt_step;
    logic [PHASE_W-1:0] phase_step;
    logic [COUNT_W-1:0] active_cnt;
    logic [PHASE_W-1:0] active_phase;
    logic               arm_event, disarm_event, led_toggle, link_ok;

    // phase tracks count modulo the blink period, wrap of count included
    always_comb
    begin
        active_cnt   = armed_reg ? disarm_cnt_reg : arm_cnt_reg;
        active_phase = armed_reg ? disarm_phase_reg : arm_phase_reg;
        cnt_step     = active_cnt + 1'b1;
        if (active_cnt == COUNT_MAX || active_phase == PHASE_LAST)
        begin
            phase_step = '0;
        end
        else
        begin
            phase_step = active_phase + 1'b1;
        end
    end

    assign left_arm = (stick.yaw_pulse < cfg.stick_low_limit)
                   && (stick.throttle_pulse < cfg.stick_low_limit);
    assign right_arm = (stick.roll_pulse < cfg.stick_low_limit)
                    && (stick.pitch_pulse > cfg.stick_high_limit);
    assign disarm_gesture = (stick.yaw_pulse > cfg.stick_high_limit)
                         && (stick.throttle_pulse < cfg.stick_low_limit);

    always_comb
    begin
        armed_next        = armed_reg;
        arm_cnt_next      = arm_cnt_reg;
        arm_phase_next    = arm_phase_reg;
        disarm_cnt_next   = disarm_cnt_reg;
        disarm_phase_next = disarm_phase_reg;
        arm_event         = 1'b0;
        disarm_event      = 1'b0;
        led_toggle        = 1'b0;
        if (!armed_reg)
        begin
            if (left_arm)
            begin
                if (right_arm)
                begin
                    arm_cnt_next   = cnt_step;
                    arm_phase_next = phase_step;
                    led_toggle     = (phase_step == '0);
                end
            end
            else
            begin
                arm_cnt_next   = '0;
                arm_phase_next = '0;
            end
            if (arm_cnt_next > cfg.arm_hold_ticks)
            begin
                arm_cnt_next   = '0;
                arm_phase_next = '0;
                armed_next     = 1'b1;
                arm_event      = 1'b1;
            end
        end
        else
        begin
            if (disarm_gesture)
            begin
                disarm_cnt_next   = cnt_step;
                disarm_phase_next = phase_step;
                led_toggle        = (phase_step == '0);
            end
            else
            begin
                disarm_cnt_next   = '0;
                disarm_phase_next = '0;
            end
            if (disarm_cnt_next == cfg.disarm_hold_ticks)
            begin
                disarm_cnt_next   = '0;
                disarm_phase_next = '0;
                armed_next        = 1'b0;
                disarm_event      = 1'b1;
            end
        end
    end

    assign link_ok = !((stick.yaw_pulse < FAILSAFE_YAW_BELOW)
                    && (stick.throttle_pulse > FAILSAFE_OTHERS_ABOVE)
                    && (stick.roll_pulse > FAILSAFE_OTHERS_ABOVE)
                    && (stick.pitch_pulse > FAILSAFE_OTHERS_ABOVE));

    assign status = {armed_next, arm_event, disarm_event, led_toggle, link_ok};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg        <= 1'b0;
            arm_cnt_reg      <= '0;
            arm_phase_reg    <= '0;
            disarm_cnt_reg   <= '0;
            disarm_phase_reg <= '0;
        end
        else if (en)
        begin
            armed_reg        <= armed_next;
            arm_cnt_reg      <= arm_cnt_next;
            arm_phase_reg    <= arm_phase_next;
            disarm_cnt_reg   <= disarm_cnt_next;
            disarm_phase_reg <= disarm_phase_next;
        end
    end

endmodule

### hw/rtl/rc_stick_arm_disarm_detector_unit.sv
// Stick gesture arming detector. Each stick word is one control tick with four receiver
// pulse widths; each tick yields exactly one status word. A tick passes through an input
// register and the arming logic into an output register, and one tick is accepted every
// cycle, limited only by the status consumer. While a finished status word waits, the
// input register still takes one more tick and then holds it, so stick_ready follows
// status_ready from there on. Configuration writes take effect at once and are meant to
// be made while no tick is in flight.
module rc_stick_arm_disarm_detector_unit #(
    parameter int BLINK_PERIOD = 20
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              stick_valid,
    output logic                              stick_ready,
    input  rcsad_pkg::stick_word_t            stick,
    output logic                              status_valid,
    input  logic                              status_ready,
    output rcsad_pkg::status_word_t           status,
    input  logic                              cfg_we,
    input  logic [rcsad_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rcsad_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rcsad_pkg::*;

    cfg_t         cfg_reg;
    stick_word_t  stick_reg;
    logic         stick_valid_reg;
    status_word_t status_reg;
    logic         status_valid_reg;
    status_word_t status_calc;
    logic         advance;

    assign advance      = stick_valid_reg && (!status_valid_reg || status_ready);
    assign stick_ready  = !stick_valid_reg || advance;
    assign status_valid = status_valid_reg;
    assign status       = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stick_low_limit   <= STICK_LOW_RESET;
            cfg_reg.stick_high_limit  <= STICK_HIGH_RESET;
            cfg_reg.arm_hold_ticks    <= ARM_HOLD_RESET;
            cfg_reg.disarm_hold_ticks <= DISARM_HOLD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_STICK_LOW:   cfg_reg.stick_low_limit   <= cfg_data[PULSE_W-1:0];
                CFG_STICK_HIGH:  cfg_reg.stick_high_limit  <= cfg_data[PULSE_W-1:0];
                CFG_ARM_HOLD:    cfg_reg.arm_hold_ticks    <= cfg_data[COUNT_W-1:0];
                CFG_DISARM_HOLD: cfg_reg.disarm_hold_ticks <= cfg_data[COUNT_W-1:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stick_valid_reg <= 1'b0;
        end
        else if (stick_ready)
        begin
            stick_valid_reg <= stick_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stick_valid && stick_ready)
        begin
            stick_reg <= stick;
        end
    end

    rcsad_eval #(
        .BLINK_PERIOD (BLINK_PERIOD)
    ) u_eval (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (advance),
        .stick  (stick_reg),
        .cfg    (cfg_reg),
        .status (status_calc)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            status_valid_reg <= 1'b1;
        end
        else if (status_ready)
        begin
            status_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg <= status_calc;
        end
    end

endmodule
